// ===== hdl/cle_pkg.sv =====
// cle_pkg: shared types and codes for the circular list engine
// used by circular_list_engine and tb; no dependencies
package cle_pkg;

    localparam int CAPACITY    = 64;
    localparam int MAX_RESULTS = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VAL_W       = 32;

    localparam logic [3:0] CMD_CREATE     = 4'd0;
    localparam logic [3:0] CMD_INS_FIRST  = 4'd1;
    localparam logic [3:0] CMD_INS_BEFORE = 4'd2;
    localparam logic [3:0] CMD_INS_AFTER  = 4'd3;
    localparam logic [3:0] CMD_INS_LAST   = 4'd4;
    localparam logic [3:0] CMD_DELETE     = 4'd5;
    localparam logic [3:0] CMD_SEARCH     = 4'd6;
    localparam logic [3:0] CMD_UPDATE     = 4'd7;
    localparam logic [3:0] CMD_DISPLAY    = 4'd8;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [3:0]               cmd;
        logic                     start_new;
        logic signed [VAL_W-1:0]  key;
        logic signed [VAL_W-1:0]  new_value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic                     found;
        logic signed [VAL_W-1:0]  element;
        logic                     last;
    } rsp_t;

endpackage

// ===== hdl/cle_ram.sv =====
// cle_ram: generic single write port, single read port ram with registered read
// no dependencies
module cle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/circular_list_engine.sv =====
// circular_list_engine: circular singly linked list kept in node memories
// depends on cle_pkg and cle_ram
//
// usage:
//   req channel carries one command transaction (req_valid / req_stall / req)
//   rsp channel returns results (rsp_valid / rsp_stall / rsp); every command
//   gives one result with last set, display gives one result per element
//   (at most 64), the final one carrying last
//   values and next links live in two ram blocks with registered reads
//   key lookups and display walk the list one node at a time (ram read, then
//   check); a lookup that writes passes through the write states before its
//   result, and simple inserts go from dispatch straight to the write states
//   one command is in flight at a time: req_stall is high until its last
//   result sits in the output register
//   a stalled result holds in the output register and the walk waits for it
//   reset empties the list at once; no clearing pass is needed
module circular_list_engine
    import cle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DISP = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_W1   = 3'd4;
    localparam logic [2:0] ST_W2   = 3'd5;
    localparam logic [2:0] ST_RESP = 3'd6;

    logic [2:0]          state_reg, state_next;
    req_t                cmd_reg, cmd_next;
    logic [IDX_W-1:0]    node_reg, node_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    free_reg, free_comb;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAPACITY-1:0] in_use_reg, in_use_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_reg, out_next;
    logic [1:0]          status_reg, status_next;
    logic                found_reg, found_next;
    logic                we1_reg, we1_next, we2_reg, we2_next, vwe_reg, vwe_next;
    logic [IDX_W-1:0]    wa1_reg, wa1_next, wd1_reg, wd1_next;
    logic [IDX_W-1:0]    wa2_reg, wa2_next, wd2_reg, wd2_next;
    logic [IDX_W-1:0]    vwa_reg, vwa_next;

    logic                    link_we;
    logic [IDX_W-1:0]        link_wa, link_wd, link_rd;
    logic signed [VAL_W-1:0] val_rd;
    logic                    out_free, full, fin;
    logic [IDX_W-1:0]        n_sel;

    cle_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_values (
        .clk   (clk),
        .we    (vwe_reg && state_reg == ST_W1),
        .waddr (vwa_reg),
        .wdata (cmd_reg.new_value),
        .raddr (node_reg),
        .rdata (val_rd)
    );

    cle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_wa),
        .wdata (link_wd),
        .raddr (node_reg),
        .rdata (link_rd)
    );

    assign link_we = (state_reg == ST_W1) ? we1_reg : (state_reg == ST_W2) && we2_reg;
    assign link_wa = (state_reg == ST_W1) ? wa1_reg : wa2_reg;
    assign link_wd = (state_reg == ST_W1) ? wd1_reg : wd2_reg;

    // lowest free node
    always_comb
    begin
        free_comb = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_comb = IDX_W'(i);
            end
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign fin       = (idx_reg + CNT_W'(1) == count_reg)
                    || (32'(idx_reg) + 32'd1 == 32'(MAX_RESULTS));
    assign n_sel     = free_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        node_next      = node_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        in_use_next    = in_use_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        we1_next       = we1_reg;
        we2_next       = we2_reg;
        vwe_next       = vwe_reg;
        wa1_next       = wa1_reg;
        wd1_next       = wd1_reg;
        wa2_next       = wa2_reg;
        wd2_next       = wd2_reg;
        vwa_next       = vwa_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next  = req;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                status_next = STAT_OK;
                found_next  = 1'b0;
                we1_next    = 1'b0;
                we2_next    = 1'b0;
                vwe_next    = 1'b0;
                node_next   = head_reg;
                prev_next   = tail_reg;
                idx_next    = '0;
                state_next  = ST_RESP;
                if (cmd_reg.cmd > CMD_DISPLAY)
                begin
                    state_next = ST_RESP;
                end
                else if (cmd_reg.cmd == CMD_CREATE)
                begin
                    if (!cmd_reg.start_new && full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        vwe_next   = 1'b1;
                        state_next = ST_W1;
                        tail_next  = cmd_reg.start_new ? IDX_W'(0) : n_sel;
                        if (cmd_reg.start_new || count_reg == '0)
                        begin
                            // first node links to itself
                            vwa_next    = tail_next;
                            head_next   = tail_next;
                            in_use_next = CAPACITY'(1) << tail_next;
                            count_next  = CNT_W'(1);
                            we1_next    = 1'b1;
                            wa1_next    = tail_next;
                            wd1_next    = tail_next;
                        end
                        else
                        begin
                            vwa_next    = n_sel;
                            in_use_next = in_use_reg | (CAPACITY'(1) << n_sel);
                            count_next  = count_reg + CNT_W'(1);
                            we1_next    = 1'b1;
                            wa1_next    = tail_reg;
                            wd1_next    = n_sel;
                            we2_next    = 1'b1;
                            wa2_next    = n_sel;
                            wd2_next    = head_reg;
                        end
                    end
                end
                else if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else if (cmd_reg.cmd == CMD_INS_FIRST || cmd_reg.cmd == CMD_INS_LAST)
                begin
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        vwe_next    = 1'b1;
                        vwa_next    = n_sel;
                        in_use_next = in_use_reg | (CAPACITY'(1) << n_sel);
                        count_next  = count_reg + CNT_W'(1);
                        we1_next    = 1'b1;
                        wa1_next    = tail_reg;
                        wd1_next    = n_sel;
                        we2_next    = 1'b1;
                        wa2_next    = n_sel;
                        wd2_next    = head_reg;
                        if (cmd_reg.cmd == CMD_INS_FIRST)
                        begin
                            head_next = n_sel;
                        end
                        else
                        begin
                            tail_next = n_sel;
                        end
                        state_next = ST_W1;
                    end
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (cmd_reg.cmd == CMD_DISPLAY)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_next.status = STAT_OK;
                        out_next.found  = 1'b0;
                        out_next.element = val_rd;
                        out_next.last   = fin;
                        node_next       = link_rd;
                        idx_next        = idx_reg + CNT_W'(1);
                        state_next      = fin ? ST_IDLE : ST_RD;
                    end
                end
                else if (val_rd == cmd_reg.key)
                begin
                    state_next = ST_RESP;
                    case (cmd_reg.cmd) inside
                        CMD_INS_BEFORE, CMD_INS_AFTER:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                vwe_next    = 1'b1;
                                vwa_next    = n_sel;
                                in_use_next = in_use_reg | (CAPACITY'(1) << n_sel);
                                count_next  = count_reg + CNT_W'(1);
                                we1_next    = 1'b1;
                                we2_next    = 1'b1;
                                wa2_next    = n_sel;
                                wd1_next    = n_sel;
                                if (cmd_reg.cmd == CMD_INS_BEFORE)
                                begin
                                    wa1_next = prev_reg;
                                    wd2_next = node_reg;
                                    if (node_reg == head_reg)
                                    begin
                                        head_next = n_sel;
                                    end
                                end
                                else
                                begin
                                    wa1_next = node_reg;
                                    wd2_next = link_rd;
                                    if (node_reg == tail_reg)
                                    begin
                                        tail_next = n_sel;
                                    end
                                end
                                state_next = ST_W1;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg == CNT_W'(1))
                            begin
                                in_use_next = '0;
                                head_next   = '0;
                                tail_next   = '0;
                                count_next  = '0;
                            end
                            else
                            begin
                                we1_next = 1'b1;
                                wa1_next = prev_reg;
                                wd1_next = link_rd;
                                if (node_reg == head_reg)
                                begin
                                    head_next = link_rd;
                                end
                                if (node_reg == tail_reg)
                                begin
                                    tail_next = prev_reg;
                                end
                                in_use_next = in_use_reg & ~(CAPACITY'(1) << node_reg);
                                count_next  = count_reg - CNT_W'(1);
                                state_next  = ST_W1;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            found_next = 1'b1;
                        end
                        default:
                        begin
                            vwe_next   = 1'b1;
                            vwa_next   = node_reg;
                            state_next = ST_W1;
                        end
                    endcase
                end
                else if (idx_reg + CNT_W'(1) >= count_reg)
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = ST_RESP;
                end
                else
                begin
                    prev_next  = node_reg;
                    node_next  = link_rd;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_W1:
            begin
                state_next = ST_W2;
            end
            ST_W2:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.status  = status_reg;
                    out_next.found   = found_reg;
                    out_next.element = '0;
                    out_next.last    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            in_use_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        node_reg   <= node_next;
        prev_reg   <= prev_next;
        idx_reg    <= idx_next;
        free_reg   <= free_comb;
        out_reg    <= out_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        we1_reg    <= we1_next;
        we2_reg    <= we2_next;
        vwe_reg    <= vwe_next;
        wa1_reg    <= wa1_next;
        wd1_reg    <= wd1_next;
        wa2_reg    <= wa2_next;
        wd2_reg    <= wd2_next;
        vwa_reg    <= vwa_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(in_use_reg)) == 32'(count_reg))
        else $error("in-use bits disagree with element count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == ST_DISP)
        else $error("accepted transaction not dispatched");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for circular_list_engine, a circular linked list store
// depends on cle_pkg and the engine rtl; predicts every result and checks it in order

class list_scoreboard;
    logic signed [31:0] vals[64];
    logic [5:0] links[64];
    bit used[64];
    int head_idx, tail_idx, count;
    cle_pkg::rsp_t pending[$];
    int errors;

    function new();
        errors = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (used[i]) used[i] = 0;
        head_idx = 0;
        tail_idx = 0;
        count = 0;
    endfunction

    function void push(logic [1:0] st, bit fnd, logic signed [31:0] el, bit lst);
        cle_pkg::rsp_t r;
        r.status = st;
        r.found = fnd;
        r.element = el;
        r.last = lst;
        pending.push_back(r);
    endfunction

    function int grab(logic signed [31:0] v);
        for (int i = 0; i < 64; i++)
        begin
            if (!used[i])
            begin
                used[i] = 1;
                vals[i] = v;
                count++;
                return i;
            end
        end
        return 64;
    endfunction

    function void link_tail(int n);
        if (count == 1)
        begin
            head_idx = n;
            links[n] = n;
        end
        else
        begin
            links[tail_idx] = n;
            links[n] = head_idx;
        end
        tail_idx = n;
    endfunction

    function void note_request(cle_pkg::req_t q);
        int node, prv, pos, n;
        pos = 64;
        if (q.cmd == cle_pkg::CMD_DISPLAY)
        begin
            if (count == 0)
            begin
                push(cle_pkg::STAT_EMPTY, 0, 0, 1);
                return;
            end
            node = head_idx;
            for (int k = 0; k < count && k < 64; k++)
            begin
                push(cle_pkg::STAT_OK, 0, vals[node], (k + 1 == count) || (k + 1 == 64));
                node = links[node];
            end
            return;
        end
        if (q.cmd > cle_pkg::CMD_DISPLAY)
        begin
            push(cle_pkg::STAT_OK, 0, 0, 1);
            return;
        end
        if (q.cmd == cle_pkg::CMD_CREATE)
        begin
            if (q.start_new) wipe();
            if (count >= 64)
                push(cle_pkg::STAT_FULL, 0, 0, 1);
            else
            begin
                n = grab(q.new_value);
                link_tail(n);
                push(cle_pkg::STAT_OK, 0, 0, 1);
            end
            return;
        end
        if (count == 0)
        begin
            push(cle_pkg::STAT_EMPTY, 0, 0, 1);
            return;
        end
        if (q.cmd == cle_pkg::CMD_INS_FIRST || q.cmd == cle_pkg::CMD_INS_LAST)
        begin
            if (count >= 64)
            begin
                push(cle_pkg::STAT_FULL, 0, 0, 1);
                return;
            end
            n = grab(q.new_value);
            if (q.cmd == cle_pkg::CMD_INS_LAST)
                link_tail(n);
            else
            begin
                links[n] = head_idx;
                links[tail_idx] = n;
                head_idx = n;
            end
            push(cle_pkg::STAT_OK, 0, 0, 1);
            return;
        end
        node = head_idx;
        prv = tail_idx;
        for (int i = 0; i < count; i++)
        begin
            if (vals[node] == q.key)
            begin
                pos = node;
                break;
            end
            prv = node;
            node = links[node];
        end
        if (pos == 64)
        begin
            push(cle_pkg::STAT_NOT_FOUND, 0, 0, 1);
            return;
        end
        case (q.cmd)
            cle_pkg::CMD_INS_BEFORE, cle_pkg::CMD_INS_AFTER:
            begin
                if (count >= 64)
                begin
                    push(cle_pkg::STAT_FULL, 0, 0, 1);
                    return;
                end
                n = grab(q.new_value);
                if (q.cmd == cle_pkg::CMD_INS_BEFORE)
                begin
                    links[prv] = n;
                    links[n] = pos;
                    if (pos == head_idx) head_idx = n;
                end
                else
                begin
                    links[n] = links[pos];
                    links[pos] = n;
                    if (pos == tail_idx) tail_idx = n;
                end
            end
            cle_pkg::CMD_DELETE:
            begin
                if (count <= 1)
                    wipe();
                else
                begin
                    links[prv] = links[pos];
                    if (pos == head_idx) head_idx = links[pos];
                    if (pos == tail_idx) tail_idx = prv;
                    used[pos] = 0;
                    count--;
                end
            end
            cle_pkg::CMD_SEARCH:
            begin
                push(cle_pkg::STAT_OK, 1, 0, 1);
                return;
            end
            default: vals[pos] = q.new_value;
        endcase
        push(cle_pkg::STAT_OK, 0, 0, 1);
    endfunction

    function void check_response(cle_pkg::rsp_t got);
        cle_pkg::rsp_t exp_r;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.status !== exp_r.status)
        begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
            errors++;
        end
        if (got.found !== exp_r.found)
        begin
            $display("%0t: found exp %0d got %0d", $time, exp_r.found, got.found);
            errors++;
        end
        if (got.element !== exp_r.element)
        begin
            $display("%0t: element exp %0d got %0d", $time, exp_r.element, got.element);
            errors++;
        end
        if (got.last !== exp_r.last)
        begin
            $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb;
    import cle_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 0;
    rsp_t rsp;

    list_scoreboard sb = new();
    bit stim_done = 0;
    bit hold_rsp = 0;
    int idle_cycles = 0;
    logic signed [31:0] recent_vals[$];

    circular_list_engine u_top (.*);

    always #4 clk = ~clk;

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 4000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_stall <= 1;
                repeat (300) @(posedge clk);
                hold_rsp = 0;
            end
            w = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w != 0)
            begin
                rsp_stall <= 1;
                repeat (w) @(posedge clk);
            end
            rsp_stall <= 0;
            @(posedge clk);
        end
    end

    task automatic send(req_t q);
        req_valid <= 1;
        req <= q;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(q);
        if (q.cmd <= CMD_UPDATE && q.cmd != CMD_DELETE && q.cmd != CMD_SEARCH)
            recent_vals.push_back(q.new_value);
        if (recent_vals.size() > 16) void'(recent_vals.pop_front());
    endtask

    task automatic send_gap(req_t q);
        int w;
        w = $urandom_range(0, 4);
        if (w != 0)
        begin
            req_valid <= 0;
            repeat (w) @(posedge clk);
        end
        send(q);
    endtask

    function automatic req_t mk(logic [3:0] c, bit s, logic signed [31:0] k,
                                logic signed [31:0] v);
        req_t q;
        q.cmd = c;
        q.start_new = s;
        q.key = k;
        q.new_value = v;
        return q;
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (recent_vals.size() != 0 && $urandom_range(0, 3) != 0)
            return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        return $urandom();
    endfunction

    task automatic drain();
        req_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [3:0] c;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // empty list cases
        for (int i = 1; i <= 8; i++)
            send_gap(mk(4'(i), 1, 5, 6));
        send(mk(4'd9, 1, -1, -1));
        send(mk(4'd15, 0, 0, 0));
        send(mk(CMD_CREATE, 1, 0, 32'sh7fffffff));
        send(mk(CMD_DELETE, 0, 32'sh7fffffff, 0));
        send(mk(CMD_CREATE, 0, 0, 32'sh80000000));
        send(mk(CMD_INS_FIRST, 1, 0, -1));
        send(mk(CMD_INS_LAST, 0, 0, 0));
        send(mk(CMD_INS_BEFORE, 0, -1, 11));
        send(mk(CMD_INS_AFTER, 0, 0, 12));
        send(mk(CMD_INS_AFTER, 0, 77, 13));
        send(mk(CMD_SEARCH, 0, 12, 0));
        send(mk(CMD_SEARCH, 0, 99, 0));
        send(mk(CMD_UPDATE, 0, 11, 32'sh7fffffff));
        send(mk(CMD_DELETE, 0, 32'sh80000000, 0));
        send(mk(CMD_DISPLAY, 0, 0, 0));
        // fill the store, then hit the full cases of create, insert first, insert last and insert before
        for (int i = 0; i < 62; i++)
            send(mk(CMD_INS_LAST, 0, 0, i));
        send(mk(CMD_CREATE, 0, 0, 1));
        send(mk(CMD_INS_FIRST, 0, 0, 1));
        send(mk(CMD_INS_BEFORE, 0, 3, 1));
        send(mk(CMD_INS_AFTER, 0, -555, 1));
        send(mk(CMD_DISPLAY, 0, 0, 0));
        drain();
        // long receiver hold-off while sender keeps offering
        hold_rsp = 1;
        send(mk(CMD_CREATE, 1, 0, 1));
        for (int i = 0; i < 6; i++)
            send(mk(CMD_INS_LAST, 0, 0, i + 100));
        drain();
        recent_vals.delete();
        for (int i = 0; i < 175; i++)
        begin
            c = 4'($urandom_range(0, 8));
            if ($urandom_range(0, 40) == 0) c = 4'($urandom_range(9, 15));
            if (c == CMD_DISPLAY && $urandom_range(0, 2) != 0) c = CMD_INS_LAST;
            send_gap(mk(c, ($urandom_range(0, 30) == 0), pick_key(), $urandom()));
            if (i == 120) drain();
        end
        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
